>>> rtl/sldt_pkg.sv
package sldt_pkg;

    // Field widths fixed by the packet format.
    localparam int SEQ_W = 64;
    localparam int CNT_W = 64;
    localparam int LATE_W = 16;
    localparam int OUTCOME_W = 3;

    // Window geometry: one slot per value of the sequence modulo the slot count.
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);

    // Late window after reset.
    localparam logic [LATE_W-1:0] LATE_RESET = LATE_W'(64);

    // Classification codes reported with every result.
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_FIRST     = 3'd0,
        OUT_AHEAD     = 3'd1,
        OUT_DUPLICATE = 3'd2,
        OUT_REORDERED = 3'd3,
        OUT_TOO_LATE  = 3'd4
    } outcome_t;

    // Classification of one item, handed from the classifier to the counters.
    typedef struct packed {
        outcome_t           outcome;
        logic [SEQ_W-1:0]   advance;
        logic [SEQ_W-1:0]   gap_m1;
    } cls_t;

    // Write request into the slot memory.
    typedef struct packed {
        logic                   en;
        logic [SLOT_IDX_W-1:0]  idx;
        logic [SEQ_W-1:0]       data;
    } slot_wr_t;

endpackage

>>> rtl/sldt_seq_if.sv
interface sldt_seq_if;

    logic                       valid;
    logic                       ready;
    logic [sldt_pkg::SEQ_W-1:0] sequence_number;

    modport source (output valid, output sequence_number, input ready);
    modport sink (input valid, input sequence_number, output ready);

endinterface

>>> rtl/sldt_result_if.sv
interface sldt_result_if;

    logic                           valid;
    logic                           ready;
    logic [sldt_pkg::OUTCOME_W-1:0] outcome;
    logic [sldt_pkg::SEQ_W-1:0]     advance;
    logic [sldt_pkg::CNT_W-1:0]     received_total;
    logic [sldt_pkg::CNT_W-1:0]     lost_total;
    logic [sldt_pkg::CNT_W-1:0]     late_total;
    logic [sldt_pkg::CNT_W-1:0]     duplicate_total;

    modport source (
        output valid, output outcome, output advance, output received_total,
        output lost_total, output late_total, output duplicate_total, input ready
    );
    modport sink (
        input valid, input outcome, input advance, input received_total,
        input lost_total, input late_total, input duplicate_total, output ready
    );

endinterface

>>> rtl/sequence_loss_dup_tracker.sv
// Channel       Role     Transaction carries
// seq_chan      sink     sequence_number
// result_chan   source   outcome, advance, received/lost/late/duplicate totals
// cfg_we/wdata  write    late_window
//
// One transaction is accepted per cycle unless a stalled result backs up the pipeline.
// The three stages are the slot memory read, the classification and the counter
// update; a slot written by the item just ahead is bypassed in the classify stage.
// Reset clears the counters, the highest sequence and the slot valid bits at once;
// no clearing pass follows. A stalled result holds the pipeline behind it.
module sequence_loss_dup_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    sldt_seq_if.sink                        seq_chan,
    sldt_result_if.source                   result_chan,
    input  logic                            cfg_we,
    input  logic [sldt_pkg::LATE_W-1:0]     cfg_wdata
);

    logic                           a_valid_reg;
    logic                           a_valid_next;
    logic                           b_valid_reg;
    logic                           b_valid_next;
    logic                           c_valid_reg;
    logic                           c_valid_next;
    logic [sldt_pkg::LATE_W-1:0]    late_window_reg;

    logic                           in_fire;
    logic                           a_move;
    logic                           b_move;
    logic                           c_fire;
    logic [sldt_pkg::SEQ_W-1:0]     rd_data;
    sldt_pkg::slot_wr_t             slot_wr;
    sldt_pkg::cls_t                 cls;

    // Pipeline advance: read stage, classify stage, result stage.
    always_comb
    begin
        c_fire = c_valid_reg && result_chan.ready;
        b_move = b_valid_reg && (!c_valid_reg || c_fire);
        a_move = a_valid_reg && (!b_valid_reg || b_move);
        seq_chan.ready = !a_valid_reg || a_move;
        in_fire = seq_chan.valid && seq_chan.ready;
        a_valid_next = in_fire || (a_valid_reg && !a_move);
        b_valid_next = a_move || (b_valid_reg && !b_move);
        c_valid_next = b_move || (c_valid_reg && !c_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // Late window register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            late_window_reg <= sldt_pkg::LATE_RESET;
        end
        else if (cfg_we)
        begin
            late_window_reg <= cfg_wdata;
        end
    end

    sldt_slot_ram u_slot_ram (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_idx  (seq_chan.sequence_number[sldt_pkg::SLOT_IDX_W-1:0]),
        .wr      (slot_wr),
        .rd_data (rd_data)
    );

    sldt_classifier u_classifier (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_fire),
        .seq_in      (seq_chan.sequence_number),
        .commit      (a_move),
        .rd_data     (rd_data),
        .late_window (late_window_reg),
        .slot_wr     (slot_wr),
        .cls         (cls)
    );

    sldt_tally u_tally (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (b_move),
        .cls             (cls),
        .outcome         (result_chan.outcome),
        .advance         (result_chan.advance),
        .received_total  (result_chan.received_total),
        .lost_total      (result_chan.lost_total),
        .late_total      (result_chan.late_total),
        .duplicate_total (result_chan.duplicate_total)
    );

    assign result_chan.valid = c_valid_reg;

    // Each result loaded counts exactly one more received transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_move |=> result_chan.received_total == $past(result_chan.received_total) + 64'd1)
        else $error("received total did not advance by one");

    // The first-ever classification can only be the very first transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_chan.valid && result_chan.outcome == sldt_pkg::OUT_FIRST)
            |-> result_chan.received_total == 64'd1)
        else $error("first outcome reported after other transactions");

    // Advance is nonzero only for an item ahead of the highest sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_chan.valid && result_chan.outcome != sldt_pkg::OUT_AHEAD)
            |-> result_chan.advance == 64'd0)
        else $error("advance reported for an item that is not ahead");

endmodule

>>> rtl/sldt_slot_ram.sv
module sldt_slot_ram (
    input  logic                                clk,
    input  logic                                rd_en,
    input  logic [sldt_pkg::SLOT_IDX_W-1:0]     rd_idx,
    input  sldt_pkg::slot_wr_t                  wr,
    output logic [sldt_pkg::SEQ_W-1:0]          rd_data
);

    logic [sldt_pkg::SEQ_W-1:0] mem [sldt_pkg::SLOT_COUNT];
    logic [sldt_pkg::SEQ_W-1:0] rd_data_reg;

    // Synchronous write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
    end

    // Synchronous read port; a read in the same cycle as a write sees the old entry.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/sldt_classifier.sv
module sldt_classifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic [sldt_pkg::SEQ_W-1:0]          seq_in,
    input  logic                                commit,
    input  logic [sldt_pkg::SEQ_W-1:0]          rd_data,
    input  logic [sldt_pkg::LATE_W-1:0]         late_window,
    output sldt_pkg::slot_wr_t                  slot_wr,
    output sldt_pkg::cls_t                      cls
);

    localparam int IDX_W = sldt_pkg::SLOT_IDX_W;
    localparam int SEQ_W = sldt_pkg::SEQ_W;

    logic [SEQ_W-1:0]       seq_reg;
    logic                   started_reg;
    logic [SEQ_W-1:0]       highest_reg;
    logic [SEQ_W-1:0]       highest_next;
    logic [sldt_pkg::SLOT_COUNT-1:0] slot_valid_reg;
    logic                   fwd_hit_reg;
    logic [IDX_W-1:0]       fwd_idx_reg;
    logic [SEQ_W-1:0]       fwd_seq_reg;
    sldt_pkg::cls_t         cls_reg;
    sldt_pkg::cls_t         cls_next;

    logic [IDX_W-1:0]       idx;
    logic [SEQ_W-1:0]       slot_seq;
    logic                   slot_match;
    logic                   ahead;
    logic                   too_late;
    logic [SEQ_W:0]         late_sum;
    logic                   write_slot;

    // Sequence number of the item whose slot read is in flight.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seq_reg <= seq_in;
        end
    end

    // Slot entry, bypassing the memory when the previous commit wrote this slot.
    always_comb
    begin
        idx = seq_reg[IDX_W-1:0];
        if (fwd_hit_reg && (fwd_idx_reg == idx))
        begin
            slot_seq = fwd_seq_reg;
        end
        else
        begin
            slot_seq = rd_data;
        end
        slot_match = slot_valid_reg[idx] && (slot_seq == seq_reg);
    end

    // Compare against the highest sequence and the late window.
    always_comb
    begin
        ahead = seq_reg > highest_reg;
        late_sum = {1'b0, seq_reg} + {{(SEQ_W + 1 - sldt_pkg::LATE_W){1'b0}}, late_window};
        too_late = late_sum < {1'b0, highest_reg};
    end

    // Classify the item and decide on the slot write.
    always_comb
    begin
        cls_next.advance = '0;
        cls_next.gap_m1 = seq_reg + ~highest_reg;
        highest_next = highest_reg;
        if (!started_reg)
        begin
            cls_next.outcome = sldt_pkg::OUT_FIRST;
            highest_next = seq_reg;
        end
        else if (ahead)
        begin
            cls_next.outcome = sldt_pkg::OUT_AHEAD;
            cls_next.advance = seq_reg - highest_reg;
            highest_next = seq_reg;
        end
        else if (too_late)
        begin
            cls_next.outcome = sldt_pkg::OUT_TOO_LATE;
        end
        else if (slot_match)
        begin
            cls_next.outcome = sldt_pkg::OUT_DUPLICATE;
        end
        else
        begin
            cls_next.outcome = sldt_pkg::OUT_REORDERED;
        end
        write_slot = cls_next.outcome inside {sldt_pkg::OUT_FIRST, sldt_pkg::OUT_AHEAD,
                                              sldt_pkg::OUT_REORDERED};
    end

    assign slot_wr.en = commit && write_slot;
    assign slot_wr.idx = idx;
    assign slot_wr.data = seq_reg;

    // Tracking state and bypass record, updated when the item commits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            highest_reg <= '0;
            slot_valid_reg <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else if (commit)
        begin
            started_reg <= 1'b1;
            highest_reg <= highest_next;
            fwd_hit_reg <= write_slot;
            if (write_slot)
            begin
                slot_valid_reg[idx] <= 1'b1;
            end
        end
    end

    // Bypass payload and the classification handed downstream.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            fwd_idx_reg <= idx;
            fwd_seq_reg <= seq_reg;
            cls_reg <= cls_next;
        end
    end

    assign cls = cls_reg;

endmodule

>>> rtl/sldt_tally.sv
module sldt_tally (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  sldt_pkg::cls_t                  cls,
    output logic [sldt_pkg::OUTCOME_W-1:0]  outcome,
    output logic [sldt_pkg::SEQ_W-1:0]      advance,
    output logic [sldt_pkg::CNT_W-1:0]      received_total,
    output logic [sldt_pkg::CNT_W-1:0]      lost_total,
    output logic [sldt_pkg::CNT_W-1:0]      late_total,
    output logic [sldt_pkg::CNT_W-1:0]      duplicate_total
);

    localparam int CNT_W = sldt_pkg::CNT_W;

    logic [CNT_W-1:0]   received_reg;
    logic [CNT_W-1:0]   lost_reg;
    logic [CNT_W-1:0]   late_reg;
    logic [CNT_W-1:0]   duplicate_reg;
    logic [CNT_W-1:0]   received_next;
    logic [CNT_W-1:0]   lost_next;
    logic [CNT_W-1:0]   late_next;
    logic [CNT_W-1:0]   duplicate_next;
    sldt_pkg::outcome_t outcome_reg;
    logic [sldt_pkg::SEQ_W-1:0] advance_reg;

    // Counter updates for one classified item; all wrap.
    always_comb
    begin
        received_next = received_reg + CNT_W'(1);
        lost_next = lost_reg;
        late_next = late_reg;
        duplicate_next = duplicate_reg;
        case (cls.outcome)
            sldt_pkg::OUT_AHEAD:     lost_next = lost_reg + cls.gap_m1;
            sldt_pkg::OUT_TOO_LATE:  late_next = late_reg + CNT_W'(1);
            sldt_pkg::OUT_REORDERED: late_next = late_reg + CNT_W'(1);
            sldt_pkg::OUT_DUPLICATE: duplicate_next = duplicate_reg + CNT_W'(1);
            default:                 lost_next = lost_reg;
        endcase
    end

    // Counters double as the result register for the totals.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            received_reg <= '0;
            lost_reg <= '0;
            late_reg <= '0;
            duplicate_reg <= '0;
        end
        else if (load)
        begin
            received_reg <= received_next;
            lost_reg <= lost_next;
            late_reg <= late_next;
            duplicate_reg <= duplicate_next;
        end
    end

    // Per-item result fields.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            outcome_reg <= cls.outcome;
            advance_reg <= cls.advance;
        end
    end

    assign outcome = outcome_reg;
    assign advance = advance_reg;
    assign received_total = received_reg;
    assign lost_total = lost_reg;
    assign late_total = late_reg;
    assign duplicate_total = duplicate_reg;

endmodule

>>> tb/sv/sequence_loss_dup_tracker_tb.sv
module sequence_loss_dup_tracker_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS = 530;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HISTORY_DEPTH = 16;
    localparam int DIRECTED_ROWS = 24;

    // One result as the block reports it.
    typedef struct packed {
        sldt_pkg::outcome_t                 outcome;
        logic [sldt_pkg::SEQ_W-1:0]         advance;
        logic [sldt_pkg::CNT_W-1:0]         received_total;
        logic [sldt_pkg::CNT_W-1:0]         lost_total;
        logic [sldt_pkg::CNT_W-1:0]         late_total;
        logic [sldt_pkg::CNT_W-1:0]         duplicate_total;
    } tracker_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_WINDOW
    } row_kind_t;

    // A directed row either sends one sequence number or sets the late window.
    typedef struct packed {
        row_kind_t                      kind;
        logic [sldt_pkg::SEQ_W-1:0]     value;
        logic                           typed;
        tracker_result_t                result;
    } directed_row_t;

    typedef enum logic [1:0] {
        IDLE_SLOW_SINK,
        IDLE_SLOW_SOURCE,
        IDLE_NONE
    } idle_mode_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [sldt_pkg::LATE_W-1:0] cfg_wdata;

    sldt_seq_if seq_chan();
    sldt_result_if result_chan();

    sequence_loss_dup_tracker dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .seq_chan   (seq_chan),
        .result_chan(result_chan),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    // Directed rows: the opening rows and the too-late case carry typed results.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM, 64'd100, 1'b1, '{sldt_pkg::OUT_FIRST, 64'd0, 64'd1, 64'd0, 64'd0, 64'd0}},
        '{ROW_ITEM, 64'd100, 1'b1,
          '{sldt_pkg::OUT_DUPLICATE, 64'd0, 64'd2, 64'd0, 64'd0, 64'd1}},
        '{ROW_ITEM, 64'd101, 1'b1, '{sldt_pkg::OUT_AHEAD, 64'd1, 64'd3, 64'd0, 64'd0, 64'd1}},
        '{ROW_ITEM, 64'd110, 1'b1, '{sldt_pkg::OUT_AHEAD, 64'd9, 64'd4, 64'd8, 64'd0, 64'd1}},
        '{ROW_ITEM, 64'd105, 1'b0, '0},
        '{ROW_ITEM, 64'd105, 1'b0, '0},
        '{ROW_ITEM, 64'd46, 1'b0, '0},
        '{ROW_ITEM, 64'd45, 1'b1,
          '{sldt_pkg::OUT_TOO_LATE, 64'd0, 64'd8, 64'd8, 64'd3, 64'd2}},
        '{ROW_ITEM, 64'd174, 1'b0, '0},
        '{ROW_ITEM, 64'd110, 1'b0, '0},
        '{ROW_ITEM, 64'd174, 1'b0, '0},
        '{ROW_ITEM, 64'd174, 1'b0, '0},
        '{ROW_ITEM, 64'd0, 1'b0, '0},
        '{ROW_ITEM, 64'h8000_0000_0000_0000, 1'b0, '0},
        '{ROW_ITEM, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{ROW_WINDOW, 64'd0, 1'b0, '0},
        '{ROW_ITEM, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{ROW_ITEM, 64'h8000_0000_0000_0000, 1'b0, '0},
        '{ROW_WINDOW, 64'd65535, 1'b0, '0},
        '{ROW_ITEM, 64'h7FFF_FFFF_FFFF_0001, 1'b0, '0},
        '{ROW_ITEM, 64'h7FFF_FFFF_FFFF_0000, 1'b0, '0},
        '{ROW_ITEM, 64'h7FFF_FFFF_FFFF_0001, 1'b0, '0},
        '{ROW_ITEM, 64'd0, 1'b0, '0},
        '{ROW_ITEM, 64'h8000_0000_0000_00FF, 1'b0, '0}
    };

    // Tracker state mirrored by the predictor.
    logic [sldt_pkg::LATE_W-1:0]        trk_late_window;
    logic                               trk_started;
    logic [sldt_pkg::SEQ_W-1:0]         trk_highest;
    logic [sldt_pkg::SEQ_W-1:0]         trk_slot_seq [sldt_pkg::SLOT_COUNT];
    logic [sldt_pkg::SLOT_COUNT-1:0]    trk_slot_valid;
    logic [sldt_pkg::CNT_W-1:0]         trk_received;
    logic [sldt_pkg::CNT_W-1:0]         trk_lost;
    logic [sldt_pkg::CNT_W-1:0]         trk_late;
    logic [sldt_pkg::CNT_W-1:0]         trk_duplicate;

    tracker_result_t expected_results [$];
    logic [sldt_pkg::SEQ_W-1:0] recent_sequences [$];
    idle_mode_t idle_mode;
    int error_count = 0;
    int quiet_cycles = 0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int sender_idle_pct();
        case (idle_mode)
            IDLE_SLOW_SINK:   return 35;
            IDLE_SLOW_SOURCE: return 64;
            default:          return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (idle_mode)
            IDLE_SLOW_SINK:   return 64;
            IDLE_SLOW_SOURCE: return 35;
            default:          return 0;
        endcase
    endfunction

    // Classify one sequence number and advance the mirrored tracker state.
    function automatic tracker_result_t classify_sequence(
        input logic [sldt_pkg::SEQ_W-1:0] seq);
        tracker_result_t res;
        logic [sldt_pkg::SLOT_IDX_W-1:0] slot;
        logic [sldt_pkg::SEQ_W-1:0] gap;
        res = '0;
        slot = seq[sldt_pkg::SLOT_IDX_W-1:0];
        trk_received = trk_received + 1'b1;
        if (!trk_started)
        begin
            trk_started = 1'b1;
            trk_highest = seq;
            trk_slot_seq[slot] = seq;
            trk_slot_valid[slot] = 1'b1;
            res.outcome = sldt_pkg::OUT_FIRST;
        end
        else if (seq > trk_highest)
        begin
            gap = seq - trk_highest;
            trk_lost = trk_lost + gap - 1'b1;
            trk_highest = seq;
            trk_slot_seq[slot] = seq;
            trk_slot_valid[slot] = 1'b1;
            res.outcome = sldt_pkg::OUT_AHEAD;
            res.advance = gap;
        end
        else if (trk_highest - seq >
                 {{(sldt_pkg::SEQ_W - sldt_pkg::LATE_W){1'b0}}, trk_late_window})
        begin
            trk_late = trk_late + 1'b1;
            res.outcome = sldt_pkg::OUT_TOO_LATE;
        end
        else if (trk_slot_valid[slot] && trk_slot_seq[slot] == seq)
        begin
            trk_duplicate = trk_duplicate + 1'b1;
            res.outcome = sldt_pkg::OUT_DUPLICATE;
        end
        else
        begin
            trk_slot_seq[slot] = seq;
            trk_slot_valid[slot] = 1'b1;
            trk_late = trk_late + 1'b1;
            res.outcome = sldt_pkg::OUT_REORDERED;
        end
        res.received_total = trk_received;
        res.lost_total = trk_lost;
        res.late_total = trk_late;
        res.duplicate_total = trk_duplicate;
        return res;
    endfunction

    // Random sequence numbers, mostly close to the highest seen so far.
    function automatic logic [sldt_pkg::SEQ_W-1:0] pick_sequence(input bit to_top);
        int unsigned roll;
        int unsigned reach;
        logic [sldt_pkg::SEQ_W-1:0] seq;
        if (to_top)
            return '1;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            seq = trk_highest + 64'($urandom_range(1, 4));
        else if (roll < 45)
            seq = trk_highest + 64'($urandom_range(5, 200));
        else if (roll < 47)
            seq = {$urandom, $urandom};
        else if (roll < 70)
        begin
            reach = int'(trk_late_window);
            if ($urandom_range(0, 1) == 0 && reach > 100)
                reach = 100;
            seq = trk_highest - 64'($urandom_range(0, reach));
        end
        else if (roll < 82 && recent_sequences.size() != 0)
            seq = recent_sequences[$urandom_range(0, recent_sequences.size() - 1)];
        else if (roll < 92)
            seq = trk_highest - 64'(trk_late_window) - 64'($urandom_range(1, 3));
        else
            seq = {$urandom, $urandom} & trk_highest;
        return seq;
    endfunction

    // Send one transaction, predict its result at acceptance, then maybe idle.
    task automatic push_sequence(input logic [sldt_pkg::SEQ_W-1:0] seq, input logic typed,
                                 input tracker_result_t typed_result);
        tracker_result_t predicted;
        seq_chan.valid <= 1'b1;
        seq_chan.sequence_number <= seq;
        do
            @(posedge clk);
        while (!(seq_chan.valid && seq_chan.ready));
        predicted = classify_sequence(seq);
        expected_results.insert(expected_results.size(), typed ? typed_result : predicted);
        recent_sequences.insert(recent_sequences.size(), seq);
        if (recent_sequences.size() > HISTORY_DEPTH)
            recent_sequences.delete(0);
        if ($urandom_range(0, 99) < sender_idle_pct())
        begin
            seq_chan.valid <= 1'b0;
            seq_chan.sequence_number <= {$urandom, $urandom};
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct());
        end
    endtask

    // Write the late window once the block has drained.
    task automatic set_late_window(input logic [sldt_pkg::LATE_W-1:0] value);
        seq_chan.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        trk_late_window = value;
    endtask

    task automatic check_field(input string label, input logic [sldt_pkg::CNT_W-1:0] want,
                               input logic [sldt_pkg::CNT_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        end
    endtask

    // Result checking and receiver stalls.
    always @(posedge clk)
    begin
        tracker_result_t want;
        if (result_chan.valid && result_chan.ready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual outcome %0d",
                         $time, result_chan.outcome);
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                check_field("outcome", 64'(want.outcome), 64'(result_chan.outcome));
                check_field("advance", want.advance, result_chan.advance);
                check_field("received_total", want.received_total,
                            result_chan.received_total);
                check_field("lost_total", want.lost_total, result_chan.lost_total);
                check_field("late_total", want.late_total, result_chan.late_total);
                check_field("duplicate_total", want.duplicate_total,
                            result_chan.duplicate_total);
            end
        end
        result_chan.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end

    // Watchdog: the run ends if no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((seq_chan.valid && seq_chan.ready) || (result_chan.valid && result_chan.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus: reset, directed rows, then three random phases.
    initial
    begin
        logic [sldt_pkg::LATE_W-1:0] window;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        seq_chan.valid = 1'b0;
        seq_chan.sequence_number = '0;
        idle_mode = IDLE_SLOW_SINK;
        trk_late_window = sldt_pkg::LATE_RESET;
        trk_started = 1'b0;
        trk_highest = '0;
        trk_slot_valid = '0;
        trk_received = '0;
        trk_lost = '0;
        trk_late = '0;
        trk_duplicate = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WINDOW)
                set_late_window(directed_rows[i].value[sldt_pkg::LATE_W-1:0]);
            else
                push_sequence(directed_rows[i].value, directed_rows[i].typed,
                              directed_rows[i].result);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       window = sldt_pkg::LATE_W'($urandom_range(1, 200));
                1:       window = '1;
                default: window = sldt_pkg::LATE_W'($urandom_range(0, 8));
            endcase
            set_late_window(window);
            idle_mode = idle_mode_t'(phase);
            // The last phase jumps to the top sequence number near its end.
            for (int i = 0; i < PHASE_ITEMS; i++)
                push_sequence(pick_sequence(phase == 2 && i == PHASE_ITEMS - 30), 1'b0, '0);
        end

        seq_chan.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
